[rtl/assert_macros.svh]
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent on the next cycle
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/scdet_pkg.sv]
// shared types, constants and helpers of the serial command and reading detector
`default_nettype none

package scdet_pkg;

  localparam int WINDOW_LEN       = 10;
  localparam int NUM_COMMANDS_DEF = 3;
  localparam int BYTE_W           = 8;
  localparam int CMD_W            = 16;
  localparam int CMD_IDX_W        = 2;
  localparam int CFG_IDX_W        = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CMD_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_C = 2'd2;

  // reset command words, older character in the high byte
  localparam logic [CMD_W-1:0] CMD_A_RESET = 16'h4378;  // "Cx"
  localparam logic [CMD_W-1:0] CMD_B_RESET = 16'h4F6B;  // "Ok"
  localparam logic [CMD_W-1:0] CMD_C_RESET = 16'h4274;  // "Bt"

  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

  // byte positions of a reading frame in the window (0 is oldest)
  localparam int POS_SIGN      = 2;
  localparam int POS_TEMP_TENS = 3;
  localparam int POS_TEMP_UNIT = 4;
  localparam int POS_DOT       = 5;
  localparam int POS_TEMP_FRAC = 6;
  localparam int POS_HUM_TENS  = 7;
  localparam int POS_HUM_UNIT  = 8;

  localparam logic EVT_COMMAND = 1'b0;
  localparam logic EVT_READING = 1'b1;

  typedef logic [WINDOW_LEN-1:0][BYTE_W-1:0] win_t;

  typedef struct packed {
    logic                 hit;
    logic                 event_kind;
    logic [CMD_IDX_W-1:0] command_index;
    logic [BYTE_W-1:0]    sign_char;
    logic [BYTE_W-1:0]    temp_tens_char;
    logic [BYTE_W-1:0]    temp_units_char;
    logic [BYTE_W-1:0]    temp_tenths_char;
    logic [BYTE_W-1:0]    humidity_tens_char;
    logic [BYTE_W-1:0]    humidity_units_char;
  } match_t;

  function automatic logic [CMD_W-1:0] cmd_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CMD_W-1:0] word;
    unique case (idx)
      REG_CMD_A: word = CMD_A_RESET;
      REG_CMD_B: word = CMD_B_RESET;
      REG_CMD_C: word = CMD_C_RESET;
      default:   word = '0;
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

[rtl/serial_command_and_reading_detector.sv]
// top level of the serial command and reading detector
`default_nettype none

// Serial command and reading detector. Each input beat carries one received
// byte, which is shifted into a ten-byte window (reset to zeros, newest byte
// at the top). The window is then checked in priority order: command 0 at
// the two oldest bytes, then a reading frame (sign '+' or '-' at byte 2,
// '.' at byte 5, XOR of bytes 2..9 zero), then the first command, in command
// order, that matches at any offset. A hit sends one output beat (command
// index, or the six reading characters) and clears the window; bytes that
// hit nothing send no beat. Timing: a byte is held in the input register
// while the window update and all compares run, and a hit is registered in
// the output register when the byte moves on. One byte is taken per cycle
// as long as the output register is empty or being drained; while a result
// waits on out_ready, one more byte is still taken and then held in the
// input register. Command words are to be written through the cfg port
// only while idle; the block itself does not enforce this. Writes to an
// index past the last command are dropped.
module serial_command_and_reading_detector #(
  parameter int NUM_COMMANDS = scdet_pkg::NUM_COMMANDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input beats
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [scdet_pkg::BYTE_W-1:0]        in_rx_byte,
  // result beats
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_event_kind,
  output logic [scdet_pkg::CMD_IDX_W-1:0]          out_command_index,
  output logic [scdet_pkg::BYTE_W-1:0]             out_sign_char,
  output logic [scdet_pkg::BYTE_W-1:0]             out_temp_tens_char,
  output logic [scdet_pkg::BYTE_W-1:0]             out_temp_units_char,
  output logic [scdet_pkg::BYTE_W-1:0]             out_temp_tenths_char,
  output logic [scdet_pkg::BYTE_W-1:0]             out_humidity_tens_char,
  output logic [scdet_pkg::BYTE_W-1:0]             out_humidity_units_char,
  // configuration writes
  input  wire logic                                cfg_wr_en,
  input  wire logic [scdet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scdet_pkg::CMD_W-1:0]         cfg_wdata
);

  // input register
  logic                            in_valid_r;
  logic                            in_valid_nxt;
  logic [scdet_pkg::BYTE_W-1:0]    in_byte_r;

  // window state and command words
  scdet_pkg::win_t                 window_r;
  scdet_pkg::win_t                 window_nxt;
  scdet_pkg::win_t                 win_shift;
  logic [NUM_COMMANDS-1:0][scdet_pkg::CMD_W-1:0] cmd_r;

  // output register
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  scdet_pkg::match_t               result;
  scdet_pkg::match_t               out_data_r;

  logic                            advance;
  logic                            in_fire;

  // byte in the input register moves on when the output register can take a hit
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  scdet_match #(
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_match (
    .win       (window_r),
    .rx_byte   (in_byte_r),
    .cmd_words (cmd_r),
    .win_shift (win_shift),
    .result    (result)
  );

  always_comb begin
    in_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  end

  // a hit wipes the window, otherwise it keeps the shifted bytes
  always_comb begin
    window_nxt = window_r;
    if (advance) begin
      window_nxt = result.hit ? '0 : win_shift;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && result.hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
    end
  end

  // command word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COMMANDS; k++) begin
        cmd_r[k] <= scdet_pkg::cmd_reset(scdet_pkg::CFG_IDX_W'(k));
      end
    end else if (cfg_wr_en) begin
      for (int k = 0; k < NUM_COMMANDS; k++) begin
        if (cfg_index == scdet_pkg::CFG_IDX_W'(k)) begin
          cmd_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance && result.hit) begin
      out_data_r <= result;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_event_kind          = out_data_r.event_kind;
  assign out_command_index       = out_data_r.command_index;
  assign out_sign_char           = out_data_r.sign_char;
  assign out_temp_tens_char      = out_data_r.temp_tens_char;
  assign out_temp_units_char     = out_data_r.temp_units_char;
  assign out_temp_tenths_char    = out_data_r.temp_tenths_char;
  assign out_humidity_tens_char  = out_data_r.humidity_tens_char;
  assign out_humidity_units_char = out_data_r.humidity_units_char;

endmodule

`default_nettype wire

[rtl/scdet_match.sv]
// window shift and prioritized command / reading frame detection
`default_nettype none

module scdet_match #(
  parameter int NUM_COMMANDS = scdet_pkg::NUM_COMMANDS_DEF
) (
  input  wire scdet_pkg::win_t                           win,
  input  wire logic [scdet_pkg::BYTE_W-1:0]              rx_byte,
  input  wire logic [NUM_COMMANDS-1:0][scdet_pkg::CMD_W-1:0] cmd_words,
  output scdet_pkg::win_t                                win_shift,
  output scdet_pkg::match_t                              result
);

  logic [NUM_COMMANDS-1:0]   cmd_any;
  logic                      cmd0_at_zero;
  logic                      frame_ok;
  logic [scdet_pkg::BYTE_W-1:0] xor_sum;
  logic                      scan_hit;
  logic [scdet_pkg::CMD_IDX_W-1:0] scan_idx;

  // shift: oldest byte drops out, new byte enters at the top
  always_comb begin
    for (int i = 0; i < scdet_pkg::WINDOW_LEN - 1; i++) begin
      win_shift[i] = win[i+1];
    end
    win_shift[scdet_pkg::WINDOW_LEN-1] = rx_byte;
  end

  // every command against every offset, in parallel
  always_comb begin
    for (int k = 0; k < NUM_COMMANDS; k++) begin
      cmd_any[k] = 1'b0;
      for (int m = 0; m < scdet_pkg::WINDOW_LEN - 1; m++) begin
        if (win_shift[m] == cmd_words[k][15:8] && win_shift[m+1] == cmd_words[k][7:0]) begin
          cmd_any[k] = 1'b1;
        end
      end
    end
    scan_hit = |cmd_any;
    scan_idx = '0;
    for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
      if (cmd_any[k]) begin
        scan_idx = scdet_pkg::CMD_IDX_W'(k);
      end
    end
  end

  assign cmd0_at_zero = (win_shift[0] == cmd_words[0][15:8]) &&
                        (win_shift[1] == cmd_words[0][7:0]);

  always_comb begin
    xor_sum = '0;
    for (int i = scdet_pkg::POS_SIGN; i < scdet_pkg::WINDOW_LEN; i++) begin
      xor_sum = xor_sum ^ win_shift[i];
    end
  end

  assign frame_ok = (win_shift[scdet_pkg::POS_SIGN] == scdet_pkg::CHAR_PLUS ||
                     win_shift[scdet_pkg::POS_SIGN] == scdet_pkg::CHAR_MINUS) &&
                    (win_shift[scdet_pkg::POS_DOT] == scdet_pkg::CHAR_DOT) &&
                    (xor_sum == '0);

  always_comb begin
    result = '0;
    priority if (cmd0_at_zero) begin
      result.hit        = 1'b1;
      result.event_kind = scdet_pkg::EVT_COMMAND;
    end else if (frame_ok) begin
      result.hit                 = 1'b1;
      result.event_kind          = scdet_pkg::EVT_READING;
      result.sign_char           = win_shift[scdet_pkg::POS_SIGN];
      result.temp_tens_char      = win_shift[scdet_pkg::POS_TEMP_TENS];
      result.temp_units_char     = win_shift[scdet_pkg::POS_TEMP_UNIT];
      result.temp_tenths_char    = win_shift[scdet_pkg::POS_TEMP_FRAC];
      result.humidity_tens_char  = win_shift[scdet_pkg::POS_HUM_TENS];
      result.humidity_units_char = win_shift[scdet_pkg::POS_HUM_UNIT];
    end else if (scan_hit) begin
      result.hit           = 1'b1;
      result.event_kind    = scdet_pkg::EVT_COMMAND;
      result.command_index = scan_idx;
    end else begin
      result.hit = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/scdet_checker.sv]
// port-level checker for the serial command and reading detector, with its bind
`default_nettype none
`include "assert_macros.svh"

module scdet_checker #(
  parameter int NUM_COMMANDS = scdet_pkg::NUM_COMMANDS_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_event_kind,
  input wire logic [scdet_pkg::CMD_IDX_W-1:0]   out_command_index,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_sign_char,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_temp_tens_char,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_temp_units_char,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_temp_tenths_char,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_humidity_tens_char,
  input wire logic [scdet_pkg::BYTE_W-1:0]      out_humidity_units_char
);

  localparam logic [scdet_pkg::CMD_IDX_W-1:0] CmdCount = scdet_pkg::CMD_IDX_W'(NUM_COMMANDS);

  // a waiting result beat stays put
  `SCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_event_kind) && $stable(out_command_index) &&
    $stable(out_sign_char) && $stable(out_humidity_units_char),
    "result beat changed while stalled")

  // command beats carry no reading characters
  `SCD_ASSERT(a_cmd_clean, clk, rst_n,
    !(out_valid && out_event_kind == scdet_pkg::EVT_COMMAND) ||
    (out_sign_char == '0 && out_temp_tens_char == '0 && out_temp_units_char == '0 &&
     out_temp_tenths_char == '0 && out_humidity_tens_char == '0 &&
     out_humidity_units_char == '0),
    "command beat with nonzero reading characters")

  // reading beats carry a real sign and index zero
  `SCD_ASSERT(a_reading_sign, clk, rst_n,
    !(out_valid && out_event_kind == scdet_pkg::EVT_READING) ||
    ((out_sign_char == scdet_pkg::CHAR_PLUS || out_sign_char == scdet_pkg::CHAR_MINUS) &&
     out_command_index == '0),
    "reading beat with bad sign or nonzero index")

  // only configured commands can match
  `SCD_ASSERT(a_cmd_range, clk, rst_n,
    !(out_valid && out_event_kind == scdet_pkg::EVT_COMMAND) ||
    (out_command_index < CmdCount),
    "command index past the last command")

endmodule

bind serial_command_and_reading_detector scdet_checker #(
  .NUM_COMMANDS (NUM_COMMANDS)
) u_scdet_checker (.*);

`default_nettype wire

[tb/sv/serial_command_and_reading_detector_tb.sv]
// testbench for the serial command and reading detector: byte stream in, event beats checked
`timescale 1ns / 100ps

module serial_command_and_reading_detector_tb;
  import scdet_pkg::*;

  // index past the last command register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam int NUM_CMDS     = NUM_COMMANDS_DEF;
  // settling wait after the last event, for margin
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 100;
  localparam int PHASE_ITEMS  = 150;

  // one event beat, field by field
  typedef struct packed {
    logic                 kind;
    logic [CMD_IDX_W-1:0] cmd;
    logic [BYTE_W-1:0]    sign;
    logic [BYTE_W-1:0]    t_tens;
    logic [BYTE_W-1:0]    t_units;
    logic [BYTE_W-1:0]    t_tenths;
    logic [BYTE_W-1:0]    h_tens;
    logic [BYTE_W-1:0]    h_units;
  } detect_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_event_kind;
  logic [CMD_IDX_W-1:0] out_command_index;
  logic [BYTE_W-1:0]    out_sign_char;
  logic [BYTE_W-1:0]    out_temp_tens_char;
  logic [BYTE_W-1:0]    out_temp_units_char;
  logic [BYTE_W-1:0]    out_temp_tenths_char;
  logic [BYTE_W-1:0]    out_humidity_tens_char;
  logic [BYTE_W-1:0]    out_humidity_units_char;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CMD_W-1:0]     cfg_wdata = '0;

  // bytes waiting for the driver, and events the block still owes us
  logic [BYTE_W-1:0] rx_stream [$];
  detect_event_t     pending_events [$];

  // our own copy of the block state
  logic [BYTE_W-1:0] win [WINDOW_LEN];
  logic [CMD_W-1:0]  cmd_word [NUM_CMDS];

  // per-phase idle limits for each side
  int in_gap_max = 0;
  int out_gap_max = 0;
  int in_gap;
  int out_stall;

  // long receiver hold-off, requested by the sequence, counted below
  bit hold_req = 1'b0;
  int hold_left;

  int errors = 0;

  serial_command_and_reading_detector DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_rx_byte              (in_rx_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_event_kind          (out_event_kind),
    .out_command_index       (out_command_index),
    .out_sign_char           (out_sign_char),
    .out_temp_tens_char      (out_temp_tens_char),
    .out_temp_units_char     (out_temp_units_char),
    .out_temp_tenths_char    (out_temp_tenths_char),
    .out_humidity_tens_char  (out_humidity_tens_char),
    .out_humidity_units_char (out_humidity_units_char),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // command word sits at window offset off, older character first
  function automatic bit pair_at(input logic [CMD_W-1:0] word, input int off);
    return win[off] == word[15:8] && win[off+1] == word[7:0];
  endfunction

  // shift one byte in, run the priority checks, queue the event on a hit
  task automatic detect_byte(input logic [BYTE_W-1:0] rx);
    detect_event_t ev;
    logic [BYTE_W-1:0] parity;
    int hit_cmd;
    bit hit;
    for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] = win[i+1];
    win[WINDOW_LEN-1] = rx;
    ev = '0;
    hit = 1'b0;
    hit_cmd = -1;
    parity = '0;
    for (int i = POS_SIGN; i < WINDOW_LEN; i++) parity ^= win[i];
    // command 0 at the two oldest bytes beats everything
    if (pair_at(cmd_word[0], 0)) begin
      hit_cmd = 0;
    // then a reading frame: sign, dot and a zero xor over bytes 2..9
    end else if ((win[POS_SIGN] == CHAR_PLUS || win[POS_SIGN] == CHAR_MINUS) &&
                 win[POS_DOT] == CHAR_DOT && parity == '0) begin
      hit = 1'b1;
      ev.kind     = EVT_READING;
      ev.sign     = win[POS_SIGN];
      ev.t_tens   = win[POS_TEMP_TENS];
      ev.t_units  = win[POS_TEMP_UNIT];
      ev.t_tenths = win[POS_TEMP_FRAC];
      ev.h_tens   = win[POS_HUM_TENS];
      ev.h_units  = win[POS_HUM_UNIT];
    // then first command in command order, lowest offset first
    end else begin
      for (int k = 0; k < NUM_CMDS; k++)
        for (int m = 0; m < WINDOW_LEN - 1; m++)
          if (hit_cmd < 0 && pair_at(cmd_word[k], m)) hit_cmd = k;
    end
    if (hit_cmd >= 0) begin
      hit = 1'b1;
      ev.kind = EVT_COMMAND;
      ev.cmd  = hit_cmd[CMD_IDX_W-1:0];
    end
    // any hit clears the whole window
    if (hit) begin
      pending_events.push_back(ev);
      for (int i = 0; i < WINDOW_LEN; i++) win[i] = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side: one byte per beat, random gap after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) detect_byte(in_rx_byte);
      // slot is free once the current beat goes or nothing is offered
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (rx_stream.size() != 0) begin
          in_rx_byte <= rx_stream.pop_front();
          in_valid   <= 1'b1;
          in_gap     <= $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: check each beat, random stall after each
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_side
    detect_event_t exp_ev;
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      stall = out_stall;
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, kind %0d index %0d",
                   $time, out_event_kind, out_command_index);
        end else begin
          exp_ev = pending_events.pop_front();
          check_field("event_kind", BYTE_W'(exp_ev.kind), BYTE_W'(out_event_kind));
          check_field("command_index", BYTE_W'(exp_ev.cmd), BYTE_W'(out_command_index));
          check_field("sign_char", exp_ev.sign, out_sign_char);
          check_field("temp_tens_char", exp_ev.t_tens, out_temp_tens_char);
          check_field("temp_units_char", exp_ev.t_units, out_temp_units_char);
          check_field("temp_tenths_char", exp_ev.t_tenths, out_temp_tenths_char);
          check_field("humidity_tens_char", exp_ev.h_tens, out_humidity_tens_char);
          check_field("humidity_units_char", exp_ev.h_units, out_humidity_units_char);
        end
        stall = $urandom_range(0, out_gap_max);
      end
      // the long hold-off overrides the per-beat stall
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // hold-off counter, lets the block back up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void send_word(input logic [CMD_W-1:0] word);
    rx_stream.push_back(word[15:8]);
    rx_stream.push_back(word[7:0]);
  endfunction

  // sign, two temp digits, dot, tenths, two humidity digits, xor byte
  // broken frames spoil the xor, the dot or the sign
  function automatic void send_reading(input logic [BYTE_W-1:0] sign,
      input logic [BYTE_W-1:0] t_tens, input logic [BYTE_W-1:0] t_units,
      input logic [BYTE_W-1:0] t_tenths, input logic [BYTE_W-1:0] h_tens,
      input logic [BYTE_W-1:0] h_units, input bit broken);
    logic [BYTE_W-1:0] frame [8];
    frame = '{sign, t_tens, t_units, CHAR_DOT, t_tenths, h_tens, h_units, 8'h00};
    for (int i = 0; i < 7; i++) frame[7] ^= frame[i];
    if (broken) begin
      case ($urandom_range(0, 2))
        0:       frame[7] ^= 8'($urandom_range(1, 255));
        1:       frame[3] = CHAR_DOT ^ 8'($urandom_range(1, 255));
        default: frame[0] = 8'h2A;  // '*' is no sign
      endcase
    end
    for (int i = 0; i < 8; i++) rx_stream.push_back(frame[i]);
  endfunction

  // mostly ascii digits, now and then any byte
  function automatic logic [BYTE_W-1:0] rand_digit();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_sign();
    return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
  endfunction

  function automatic logic [CMD_W-1:0] rand_word(input bit printable);
    if (printable) return {8'($urandom_range(33, 126)), 8'($urandom_range(33, 126))};
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly whole commands and frames, some broken frames, cut frames and noise
  function automatic void queue_random(input int count);
    int sent;
    int pick;
    int cut;
    logic [CMD_W-1:0] word;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      word = cmd_word[$urandom_range(0, NUM_CMDS - 1)];
      if (pick < 45) begin
        send_word(word);
        sent += 2;
      end else if (pick < 75) begin
        send_reading(rand_sign(), rand_digit(), rand_digit(), rand_digit(), rand_digit(),
                     rand_digit(), pick >= 70);
        sent += 8;
      end else if (pick < 85) begin
        // frame that stops partway
        cut = $urandom_range(1, 5);
        rx_stream.push_back(rand_sign());
        for (int i = 1; i < cut; i++) rx_stream.push_back(rand_digit());
        sent += cut;
      end else begin
        if ($urandom_range(0, 1)) rx_stream.push_back(8'($urandom_range(0, 255)));
        else rx_stream.push_back($urandom_range(0, 1) ? word[15:8] : word[7:0]);
        sent += 1;
      end
    end
  endfunction

  // all three command registers plus a dropped write past the end
  task automatic write_commands(input logic [CMD_W-1:0] word_a,
      input logic [CMD_W-1:0] word_b, input logic [CMD_W-1:0] word_c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CMD_A;
    cfg_wdata <= word_a;
    @(posedge clk);
    cmd_word[0] = word_a;
    cfg_index <= REG_CMD_B;
    cfg_wdata <= word_b;
    @(posedge clk);
    cmd_word[1] = word_b;
    cfg_index <= REG_CMD_C;
    cfg_wdata <= word_c;
    @(posedge clk);
    cmd_word[2] = word_c;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= rand_word(1'b0);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic start_phase(input int in_gap_lim, input int out_gap_lim);
    @(negedge clk);
    in_gap_max  = in_gap_lim;
    out_gap_max = out_gap_lim;
  endtask

  // idle means every byte taken and every event delivered; bytes that hit
  // nothing leave no trace, so let the pipe run dry after that
  task automatic finish_phase();
    @(negedge clk);
    while (rx_stream.size() != 0 || in_valid || pending_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CMD_W-1:0] shared;
    for (int i = 0; i < WINDOW_LEN; i++) win[i] = '0;
    cmd_word[0] = CMD_A_RESET;
    cmd_word[1] = CMD_B_RESET;
    cmd_word[2] = CMD_C_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset command words: each command, a good reading, a broken one
    start_phase(0, 0);
    send_word(CMD_B_RESET);
    send_word(CMD_C_RESET);
    send_word(CMD_A_RESET);
    send_reading(CHAR_PLUS, 8'h32, 8'h31, 8'h35, 8'h34, 8'h37, 1'b0);
    send_reading(CHAR_MINUS, 8'h30, 8'h33, 8'h37, 8'h39, 8'h39, 1'b1);
    finish_phase();

    // extreme words, zero word matching a window of zeros
    write_commands(16'hFFFF, 16'h0000, 16'hFFFF);
    start_phase(0, 0);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    finish_phase();

    // command 0 of zero wins at the oldest bytes; b and c share a word
    write_commands(16'h0000, CMD_B_RESET, CMD_B_RESET);
    start_phase(0, 0);
    rx_stream.push_back(8'h4F);
    rx_stream.push_back(8'h6B);
    finish_phase();

    // random phases, each with its own command words and idle pattern
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_commands(CMD_A_RESET, CMD_B_RESET, CMD_C_RESET);
        2, 6:    write_commands(rand_word(1'b0), rand_word(1'b0), rand_word(1'b0));
        3: begin
          shared = rand_word(1'b1);
          write_commands(rand_word(1'b1), shared, shared);
        end
        4:       write_commands(16'hFFFF, 16'hFF00, 16'h00FF);
        default: write_commands(rand_word(1'b1), rand_word(1'b1), rand_word(1'b1));
      endcase
      start_phase(p[0] ? 0 : 14, p[1] ? 0 : 14);
      queue_random(PHASE_ITEMS);
      // sender runs flat out here, so a long hold-off backs the block up
      if (p == 1 || p == 5) hold_req = 1'b1;
      finish_phase();
    end

    if (errors == 0 && pending_events.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
